// ----- hdl/ths_pkg.sv -----
// Shared types and constants for the TLS handshake type scanner.
package ths_pkg;

    localparam logic [7:0] CT_MIN          = 8'd20;
    localparam logic [7:0] CT_MAX          = 8'd23;
    localparam logic [7:0] CT_HANDSHAKE    = 8'd22;
    localparam logic [7:0] MAJOR_VERSION   = 8'h03;
    localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
    localparam logic [7:0] HS_CERTIFICATE  = 8'd11;

    // record header byte positions
    localparam logic [2:0] HDR_TYPE   = 3'd0;
    localparam logic [2:0] HDR_MAJOR  = 3'd1;
    localparam logic [2:0] HDR_MINOR  = 3'd2;
    localparam logic [2:0] HDR_LEN_HI = 3'd3;
    localparam logic [2:0] HDR_BODY   = 3'd5;

    // handshake header byte positions
    localparam logic [2:0] MSG_TYPE     = 3'd0;
    localparam logic [2:0] MSG_LEN_LO   = 3'd3;
    localparam logic [2:0] MSG_SKIPPING = 3'd4;

    typedef struct packed {
        logic        scan_stopped;
        logic [2:0]  record_header_index;
        logic        record_header_valid;
        logic        record_is_handshake;
        logic [15:0] record_length;
        logic [15:0] record_bytes_left;
        logic [2:0]  msg_header_index;
        logic [7:0]  msg_type_latch;
        logic [24:0] msg_skip_left;
        logic        tls_seen;
        logic        hello_seen;
        logic        cert_seen;
    } ths_state_t;

    localparam ths_state_t STATE_RESET = '0;

endpackage

// ----- hdl/ths_scan_step.sv -----
// Next-state logic of the record walker for one buffer byte.
module ths_scan_step
    import ths_pkg::*;
(
    input  ths_state_t cur,
    input  logic [7:0] data_byte,
    output ths_state_t nxt
);

    logic [15:0] len_full;
    logic [15:0] left_dec;
    logic [24:0] skip_dec;
    logic [24:0] skip_shift;

    assign len_full   = {cur.record_length[15:8], data_byte};
    assign left_dec   = cur.record_bytes_left - 16'd1;
    assign skip_dec   = cur.msg_skip_left - 25'd1;
    assign skip_shift = {1'b0, cur.msg_skip_left[15:0], data_byte};

    always_comb
    begin
        nxt = cur;
        if (!cur.scan_stopped)
        begin
            if (cur.record_header_index < HDR_BODY)
            begin
                case (cur.record_header_index)
                    HDR_TYPE:
                    begin
                        if (data_byte < CT_MIN || data_byte > CT_MAX)
                        begin
                            nxt.scan_stopped = 1'b1;
                        end
                        else
                        begin
                            nxt.record_is_handshake = (data_byte == CT_HANDSHAKE);
                            nxt.record_header_index = HDR_MAJOR;
                        end
                    end
                    HDR_MAJOR:
                    begin
                        if (data_byte != MAJOR_VERSION)
                        begin
                            nxt.scan_stopped = 1'b1;
                        end
                        else
                        begin
                            nxt.record_header_index = HDR_MINOR;
                        end
                    end
                    HDR_MINOR:
                    begin
                        nxt.record_header_index = HDR_LEN_HI;
                    end
                    HDR_LEN_HI:
                    begin
                        nxt.record_length       = {data_byte, 8'd0};
                        nxt.record_header_index = HDR_LEN_HI + 3'd1;
                    end
                    default:
                    begin
                        nxt.record_length = len_full;
                        nxt.tls_seen      = 1'b1;
                        if (len_full == 16'd0)
                        begin
                            // empty record ends the walk
                            nxt.scan_stopped = 1'b1;
                        end
                        else
                        begin
                            nxt.record_header_valid = 1'b1;
                            nxt.record_bytes_left   = len_full;
                            nxt.msg_header_index    = MSG_TYPE;
                            nxt.msg_type_latch      = 8'd0;
                            nxt.msg_skip_left       = 25'd0;
                            nxt.record_header_index = HDR_BODY;
                        end
                    end
                endcase
            end
            else
            begin
                if (cur.record_is_handshake)
                begin
                    if (cur.msg_header_index >= MSG_SKIPPING)
                    begin
                        nxt.msg_skip_left = skip_dec;
                        if (skip_dec == 25'd0)
                        begin
                            nxt.msg_header_index = MSG_TYPE;
                        end
                    end
                    else if (cur.msg_header_index == MSG_TYPE)
                    begin
                        nxt.msg_type_latch   = data_byte;
                        nxt.msg_skip_left    = 25'd0;
                        nxt.msg_header_index = MSG_TYPE + 3'd1;
                    end
                    else
                    begin
                        nxt.msg_skip_left = skip_shift;
                        if (cur.msg_header_index < MSG_LEN_LO)
                        begin
                            nxt.msg_header_index = cur.msg_header_index + 3'd1;
                        end
                        else
                        begin
                            if (cur.msg_type_latch == HS_SERVER_HELLO)
                            begin
                                nxt.hello_seen = 1'b1;
                            end
                            if (cur.msg_type_latch == HS_CERTIFICATE)
                            begin
                                nxt.cert_seen = 1'b1;
                            end
                            nxt.msg_header_index =
                                (skip_shift == 25'd0) ? MSG_TYPE : MSG_SKIPPING;
                        end
                    end
                end
                nxt.record_bytes_left = left_dec;
                if (left_dec == 16'd0)
                begin
                    // record done: drop any partial handshake header
                    nxt.record_header_index = HDR_TYPE;
                    nxt.record_header_valid = 1'b0;
                    nxt.record_is_handshake = 1'b0;
                    nxt.record_length       = 16'd0;
                    nxt.msg_header_index    = MSG_TYPE;
                    nxt.msg_type_latch      = 8'd0;
                    nxt.msg_skip_left       = 25'd0;
                end
            end
        end
    end

endmodule

// ----- hdl/tls_handshake_type_scanner_core.sv -----
// Top level of the TLS handshake type scanner: input register, scan state, result register.
// Feed a buffer one byte per item, with last_byte set on its final byte. The block takes
// one byte every cycle while not stalled; the scan state is updated in a single pass per
// byte, so the rate is set by that one registered update. A result item (three sticky
// flags) is registered as the final byte leaves the input register, and all scan state
// clears behind it so the next buffer can follow at once. The input keeps flowing while a
// result waits, except that a second final byte holds until the waiting result is taken.
module tls_handshake_type_scanner_core
    import ths_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       tls_detected,
    output logic       hello_detected,
    output logic       cert_detected
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_data_reg;
    logic       s1_last_reg;
    logic       s1_advance;
    logic       out_free;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] out_flags_reg;

    ths_state_t state_reg;
    ths_state_t state_next;
    ths_state_t step_next;

    ths_scan_step u_step (
        .cur       (state_reg),
        .data_byte (s1_data_reg),
        .nxt       (step_next)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;

    assign s1_valid_next  = in_valid || (s1_valid_reg && !s1_advance);
    assign out_valid_next = (s1_advance && s1_last_reg) || (out_valid_reg && out_stall);

    always_comb
    begin
        state_next = state_reg;
        if (s1_advance)
        begin
            state_next = s1_last_reg ? STATE_RESET : step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_advance && s1_last_reg)
        begin
            out_flags_reg <= {step_next.tls_seen, step_next.hello_seen, step_next.cert_seen};
        end
    end

    assign out_valid      = out_valid_reg;
    assign tls_detected   = out_flags_reg[2];
    assign hello_detected = out_flags_reg[1];
    assign cert_detected  = out_flags_reg[0];

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> out_valid_reg)
        else $error("final byte did not produce a result item");

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (state_reg == STATE_RESET))
        else $error("scan state not cleared after final byte");

    a_body_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.record_header_index == HDR_BODY) == state_reg.record_header_valid)
        else $error("record body position and header valid disagree");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked final byte");
`endif

endmodule

// ----- sim/tls_handshake_type_scanner_core_checker.sv -----
// Scoreboard for the TLS handshake type scanner: byte-level scan predictor and flag compare.
module tls_handshake_type_scanner_core_checker
    import ths_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        tls_detected,
    input  logic        hello_detected,
    input  logic        cert_detected,
    output int          fail_count,
    output int          flags_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_AFTER = 100;

    typedef struct packed {
        logic tls;
        logic hello;
        logic cert;
    } scan_flags_t;

    ths_state_t  scan;
    scan_flags_t flags_q[$];

    // Walk one byte of the buffer through the record and handshake header parser.
    function automatic ths_state_t next_scan(input ths_state_t s, input logic [7:0] b);
        ths_state_t n;
        n = s;
        if (s.scan_stopped)
            return n;
        if (s.record_header_index < HDR_BODY)
        begin
            case (s.record_header_index)
                HDR_TYPE:
                    if (b < CT_MIN || b > CT_MAX)
                        n.scan_stopped = 1'b1;
                    else
                    begin
                        n.record_is_handshake = (b == CT_HANDSHAKE);
                        n.record_header_index = HDR_MAJOR;
                    end
                HDR_MAJOR:
                    if (b != MAJOR_VERSION)
                        n.scan_stopped = 1'b1;
                    else
                        n.record_header_index = HDR_MINOR;
                HDR_MINOR:
                    n.record_header_index = HDR_LEN_HI;
                HDR_LEN_HI:
                begin
                    n.record_length = {b, 8'h00};
                    n.record_header_index = HDR_LEN_HI + 3'd1;
                end
                default:
                begin
                    n.record_length = s.record_length | {8'h00, b};
                    n.tls_seen = 1'b1;
                    // zero-length record still counts as TLS, then stop
                    if (n.record_length == '0)
                        n.scan_stopped = 1'b1;
                    else
                    begin
                        n.record_header_valid = 1'b1;
                        n.record_bytes_left = n.record_length;
                        n.msg_header_index = MSG_TYPE;
                        n.msg_type_latch = '0;
                        n.msg_skip_left = '0;
                        n.record_header_index = HDR_BODY;
                    end
                end
            endcase
        end
        else
        begin
            if (s.record_is_handshake)
            begin
                if (s.msg_header_index >= MSG_SKIPPING)
                begin
                    n.msg_skip_left = s.msg_skip_left - 25'd1;
                    if (n.msg_skip_left == '0)
                        n.msg_header_index = MSG_TYPE;
                end
                else if (s.msg_header_index == MSG_TYPE)
                begin
                    n.msg_type_latch = b;
                    n.msg_skip_left = '0;
                    n.msg_header_index = MSG_TYPE + 3'd1;
                end
                else
                begin
                    // gather the 24-bit message length, big-endian
                    n.msg_skip_left = {1'b0, s.msg_skip_left[15:0], b};
                    if (s.msg_header_index < MSG_LEN_LO)
                        n.msg_header_index = s.msg_header_index + 3'd1;
                    else
                    begin
                        if (s.msg_type_latch == HS_SERVER_HELLO)
                            n.hello_seen = 1'b1;
                        if (s.msg_type_latch == HS_CERTIFICATE)
                            n.cert_seen = 1'b1;
                        n.msg_header_index = (n.msg_skip_left == '0) ? MSG_TYPE : MSG_SKIPPING;
                    end
                end
            end
            n.record_bytes_left = s.record_bytes_left - 16'd1;
            // record end drops any partial handshake header or skip in progress
            if (n.record_bytes_left == '0)
            begin
                n.record_header_index = HDR_TYPE;
                n.record_header_valid = 1'b0;
                n.record_is_handshake = 1'b0;
                n.record_length = '0;
                n.msg_header_index = MSG_TYPE;
                n.msg_type_latch = '0;
                n.msg_skip_left = '0;
            end
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        if (fail_count < QUIET_AFTER)
            $display("[%0t] %s: got %b, expected %b", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_flags_t want;
        if (!rst_n)
        begin
            scan = STATE_RESET;
            flags_q.delete();
            fail_count = 0;
            flags_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (flags_q.size() == 0)
                    report_mismatch("result with nothing expected", out_valid, 1'b0);
                else
                begin
                    want = flags_q.pop_front();
                    if (tls_detected !== want.tls)
                        report_mismatch("tls_detected", tls_detected, want.tls);
                    if (hello_detected !== want.hello)
                        report_mismatch("hello_detected", hello_detected, want.hello);
                    if (cert_detected !== want.cert)
                        report_mismatch("cert_detected", cert_detected, want.cert);
                end
            end
            if (in_valid && !in_stall)
            begin
                scan = next_scan(scan, data_byte);
                if (last_byte)
                begin
                    flags_q.push_back('{scan.tls_seen, scan.hello_seen, scan.cert_seen});
                    scan = STATE_RESET;
                end
            end
            flags_pending <= flags_q.size();
        end
    end

endmodule

// ----- sim/tls_handshake_type_scanner_core_tb.sv -----
// Testbench top for the TLS handshake type scanner: buffer stimulus, receiver stalls, verdict.
module tls_handshake_type_scanner_core_tb;
    import ths_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1650;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;

    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall;
    logic       tls_detected;
    logic       hello_detected;
    logic       cert_detected;
    int         fail_count;
    int         flags_pending;

    logic [7:0] frame_bytes[$];
    int         burst_left;
    int         items_sent;
    int         idle_cycles;
    bit         hold_off_go;

    tls_handshake_type_scanner_core i_dut (.*);

    tls_handshake_type_scanner_core_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one byte, inserting a random gap (possibly none) at the start of each burst.
    task automatic send_item(input logic [7:0] b, input logic fin);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(150, 400);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 30);
                gap = $urandom_range(0, 6);
            end
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_frame();
        items_sent += frame_bytes.size();
        foreach (frame_bytes[i])
            send_item(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (flags_pending != 0)
            @(posedge clk);
    endtask

    // Append one record; handshake bodies carry a chain of messages cut at the record end.
    task automatic add_record(input logic [7:0] ctype, input int body_len, input bit len_lies);
        logic [7:0]  body[$];
        logic [23:0] msg_len;
        logic [15:0] rec_len;
        int          take;
        if (ctype == CT_HANDSHAKE)
        begin
            while (body.size() < body_len)
            begin
                case ($urandom_range(0, 5))
                    0, 1: body.push_back(HS_SERVER_HELLO);
                    2: body.push_back(HS_CERTIFICATE);
                    default: body.push_back(8'($urandom));
                endcase
                msg_len = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
                body.push_back(msg_len[23:16]);
                body.push_back(msg_len[15:8]);
                body.push_back(msg_len[7:0]);
                take = (msg_len < 24) ? int'(msg_len) : 24;
                repeat (take) body.push_back(8'($urandom));
            end
            while (body.size() > body_len)
                body.delete(body.size() - 1);
        end
        else
            repeat (body_len) body.push_back(8'($urandom));
        rec_len = len_lies ? 16'($urandom) : 16'(body_len);
        frame_bytes.push_back(ctype);
        frame_bytes.push_back(MAJOR_VERSION);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(rec_len[15:8]);
        frame_bytes.push_back(rec_len[7:0]);
        foreach (body[i])
            frame_bytes.push_back(body[i]);
    endtask

    task automatic add_records();
        logic [7:0] ctype;
        int         body_len;
        repeat ($urandom_range(1, 3))
        begin
            ctype = ($urandom_range(0, 9) < 6) ? CT_HANDSHAKE : 8'($urandom_range(CT_MIN, CT_MAX));
            body_len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 28);
            add_record(ctype, body_len, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic add_noise(input int len);
        frame_bytes.push_back(8'($urandom_range(CT_MIN - 2, CT_MAX + 2)));
        repeat (len - 1) frame_bytes.push_back(8'($urandom));
    endtask

    initial
    begin : receiver
        stall_style_t style;
        int unsigned  style_left;
        int unsigned  tick;
        out_stall <= 1'b0;
        style = STALL_NONE;
        style_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off_go)
            begin
                hold_off_go = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (style_left == 0)
                begin
                    style = stall_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 300);
                end
                style_left--;
                case (style)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_HALF: out_stall <= ($urandom_range(0, 1) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tls_handshake_type_scanner_core regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int  pick;
        bit  held;
        bit  paused;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        burst_left = 0;
        items_sent = 0;
        hold_off_go = 1'b0;
        held = 1'b0;
        paused = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short buffer
        frame_bytes = '{CT_HANDSHAKE};
        send_frame();
        // zero-length record at the low content type
        frame_bytes = '{CT_MIN, MAJOR_VERSION, 8'h00, 8'h00, 8'h00};
        send_frame();
        // bad major version
        frame_bytes = '{CT_MAX, 8'h02};
        send_frame();
        // ServerHello and Certificate headers with empty bodies
        frame_bytes = '{CT_HANDSHAKE, MAJOR_VERSION, 8'h03, 8'h00, 8'h08,
                        HS_SERVER_HELLO, 8'h00, 8'h00, 8'h00,
                        HS_CERTIFICATE, 8'h00, 8'h00, 8'h00};
        send_frame();
        frame_bytes = '{8'hFF, 8'h00};
        send_frame();
        // content types just outside the range
        frame_bytes = '{CT_MAX + 8'd1};
        send_frame();
        frame_bytes = '{CT_MIN - 8'd1};
        send_frame();

        while (items_sent < ITEM_TARGET)
        begin
            frame_bytes.delete();
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                add_records();
                // truncated buffer
                if ($urandom_range(0, 4) == 0)
                    frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 1)];
            end
            else if (pick < 85)
            begin
                add_records();
                frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
            end
            else if (pick < 95)
                add_noise($urandom_range(1, 30));
            else
                add_noise($urandom_range(1, 4));

            if (!paused && items_sent > ITEM_TARGET / 4)
            begin
                paused = 1'b1;
                drain();
            end
            else if ($urandom_range(0, 19) == 0)
                drain();

            send_frame();

            // receiver holds off while short buffers pile up behind the result
            if (!held && items_sent > ITEM_TARGET / 2)
            begin
                held = 1'b1;
                drain();
                hold_off_go = 1'b1;
                repeat (30)
                begin
                    frame_bytes.delete();
                    add_noise($urandom_range(1, 5));
                    send_frame();
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && flags_pending == 0)
            $display("tls_handshake_type_scanner_core regression: pass");
        else
            $display("tls_handshake_type_scanner_core regression: fail");
        $finish;
    end

endmodule
